[src/hufd_pkg.sv]
// Shared types and constants of the Huffman tree-walk decoder.
package hufd_pkg;

   localparam int NODE_COUNT     = 256;
   localparam int NODE_W         = $clog2(NODE_COUNT);
   localparam int BRANCH_W       = 16;
   localparam int ENTRY_W        = 2 * BRANCH_W;
   localparam int LEN_W          = 16;
   localparam int SYM_W          = 8;
   localparam int BYTE_W         = 8;
   localparam int BIT_CNT_W      = $clog2(BYTE_W);
   localparam int HEAD_NODE_DEF  = 254;
   localparam int MAX_LENGTH_DEF = 65000;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_DATA  = 2'd2
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } state_type;

endpackage

[src/hufd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hufd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/huffman_tree_decoder_top.sv]
// Top level of the Huffman tree-walk decoder.
//
// The decoder walks a binary tree of 256 nodes held in one synchronous RAM
// (32 bits per node: zero branch low, one branch high). A load transfer
// writes one node in its accept cycle; a start transfer sets the output
// length and rewinds the walk to the head node. A data transfer is accepted
// and then walks one compressed bit per cycle while the output is not held:
// each bit needs the node word read by the previous bit, and the RAM's
// registered read data sets that pace. A byte that completes the block
// finishes early, at the bit that gives the last symbol. A decoded symbol
// waits in an output register; when that register is still full the walk
// holds on the bit that would emit, so no symbol is lost under
// back-pressure. Nodes that were never loaded read as undefined, so the
// tree must be loaded before it is walked. Lengths of zero or above
// MAX_LENGTH leave the decoder inactive, and data transfers are then
// swallowed without result. Input is taken only between bytes.
module huffman_tree_decoder_top #(
   parameter int HEAD_NODE  = hufd_pkg::HEAD_NODE_DEF,
   parameter int MAX_LENGTH = hufd_pkg::MAX_LENGTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_command,
   input  logic [hufd_pkg::NODE_W-1:0]   req_node_index,
   input  logic [hufd_pkg::BRANCH_W-1:0] req_branch_zero,
   input  logic [hufd_pkg::BRANCH_W-1:0] req_branch_one,
   input  logic [hufd_pkg::LEN_W-1:0]    req_out_length,
   input  logic [hufd_pkg::BYTE_W-1:0]   req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hufd_pkg::SYM_W-1:0]    rsp_symbol,
   output logic                          rsp_last
);

   import hufd_pkg::*;

   localparam logic [NODE_W-1:0] HEAD    = NODE_W'(HEAD_NODE);
   localparam logic [LEN_W-1:0]  MAX_LEN = LEN_W'(MAX_LENGTH);

   // walk state
   state_type               state_ff, state_in;
   logic [NODE_W-1:0]       current_node_ff, current_node_in;
   logic [LEN_W-1:0]        remaining_ff, remaining_in;
   logic                    active_ff, active_in;
   logic [BYTE_W-1:0]       byte_ff, byte_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]        rsp_symbol_ff, rsp_symbol_in;
   logic                    rsp_last_ff, rsp_last_in;

   // node RAM
   logic                    ram_wr_en;
   logic                    ram_rd_en;
   logic [NODE_W-1:0]       ram_rd_addr;
   logic [ENTRY_W-1:0]      ram_rd_data;

   // bit evaluation
   logic                    req_fire;
   cmd_type                 cmd;
   logic [BRANCH_W-1:0]     branch;
   logic                    emit;
   logic                    move;
   logic                    stall;
   logic                    finish;
   logic [NODE_W-1:0]       walk_node;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign cmd       = cmd_type'(req_command);
   assign ram_wr_en = req_fire && (cmd == CMD_LOAD);

   hufd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_node_index),
      .wr_data ({req_branch_one, req_branch_zero}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // LSB of the shifted byte picks the branch of the node just read
   assign branch = byte_ff[0] ? ram_rd_data[ENTRY_W-1:BRANCH_W]
                              : ram_rd_data[BRANCH_W-1:0];
   assign emit   = (branch[BRANCH_W-1:SYM_W] == '0);
   assign move   = (branch[BRANCH_W-1:NODE_W+1] == '0) && branch[NODE_W];
   // symbol due but output register still occupied
   assign stall  = emit && rsp_valid_ff && !rsp_ready;
   assign finish = emit && (remaining_ff == LEN_W'(1));

   always_comb begin
      if (emit) begin
         walk_node = HEAD;
      end else if (move) begin
         walk_node = branch[NODE_W-1:0];
      end else begin
         walk_node = current_node_ff;
      end
   end

   always_comb begin
      state_in        = state_ff;
      current_node_in = current_node_ff;
      remaining_in    = remaining_ff;
      active_in       = active_ff;
      byte_in         = byte_ff;
      bit_cnt_in      = bit_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_symbol_in   = rsp_symbol_ff;
      rsp_last_in     = rsp_last_ff;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = current_node_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  CMD_LOAD: begin
                     // written straight into the RAM
                  end
                  CMD_START: begin
                     current_node_in = HEAD;
                     if (req_out_length == '0 || req_out_length > MAX_LEN) begin
                        active_in    = 1'b0;
                        remaining_in = '0;
                     end else begin
                        active_in    = 1'b1;
                        remaining_in = req_out_length;
                     end
                  end
                  CMD_DATA: begin
                     if (active_ff) begin
                        byte_in    = req_data_byte;
                        bit_cnt_in = '0;
                        ram_rd_en  = 1'b1;
                        state_in   = ST_WALK;
                     end
                  end
                  default: begin
                     // unused command: dropped
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (!stall) begin
               current_node_in = walk_node;
               if (emit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_symbol_in = branch[SYM_W-1:0];
                  rsp_last_in   = finish;
                  remaining_in  = remaining_ff - LEN_W'(1);
               end
               if (finish) begin
                  active_in = 1'b0;
                  state_in  = ST_IDLE;
               end else if (bit_cnt_ff == BIT_CNT_W'(BYTE_W - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = walk_node;
                  byte_in     = byte_ff >> 1;
                  bit_cnt_in  = bit_cnt_ff + BIT_CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         current_node_ff <= HEAD;
         remaining_ff    <= '0;
         active_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         current_node_ff <= current_node_in;
         remaining_ff    <= remaining_in;
         active_ff       <= active_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      byte_ff       <= byte_in;
      bit_cnt_ff    <= bit_cnt_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

   // walking only happens inside an active block
   a_walk_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> active_ff)
      else $error("walk without active block");

   // an active block always has symbols left to produce
   a_active_count: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (remaining_ff != '0))
      else $error("active block with zero count");

   // final symbol closes the block
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && !stall && finish)
         |=> (state_ff == ST_IDLE) && !active_ff && rsp_valid_ff && rsp_last_ff)
      else $error("block not closed after last symbol");

   // a held bit keeps the walk position
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && stall)
         |=> (state_ff == ST_WALK) && $stable(bit_cnt_ff) && $stable(current_node_ff))
      else $error("walk moved while output was full");

endmodule
